// File: design/mtw_pkg.sv
// Shared constants, types and the wheel pattern table of the trigger wheel generator.
package mtw_pkg;

   localparam int WHEEL_TABLE_SIZE = 5;

   localparam int RPM_W      = 15;
   localparam int INTERVAL_W = 23;
   localparam int TOOTH_W    = 6;
   localparam int WSEL_W     = 3;
   localparam int MISSING_W  = 2;
   localparam int DIVIDEND_W = 26;
   localparam int DIVISOR_W  = RPM_W + TOOTH_W;
   localparam int STEP_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [DIVIDEND_W-1:0] MICROS_PER_MINUTE = 26'd60000000;
   localparam logic [RPM_W-1:0]      RPM_RESET         = 15'd1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE = 2'd0,
      CSR_RPM    = 2'd1,
      CSR_WHEEL  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TOOTH_W-1:0]   teeth;
      logic [MISSING_W-1:0] missing;
   } wheel_type;

   function automatic wheel_type wheel_lookup(input logic [WSEL_W-1:0] sel);
      wheel_type w;
      case (sel)
         3'd0:    w = '{teeth: 6'd36, missing: 2'd1};
         3'd1:    w = '{teeth: 6'd60, missing: 2'd2};
         3'd2:    w = '{teeth: 6'd24, missing: 2'd1};
         3'd3:    w = '{teeth: 6'd12, missing: 2'd2};
         3'd4:    w = '{teeth: 6'd12, missing: 2'd0};
         default: w = '{teeth: 6'd36, missing: 2'd1};
      endcase
      return w;
   endfunction

endpackage

// File: design/mtw_if.sv
// Handshake interfaces for the alarm, result and register write channels.
interface mtw_req_if;
   logic valid;
   logic ready;
   logic alarm_tick;
   modport source (output valid, output alarm_tick, input ready);
   modport sink   (input valid, input alarm_tick, output ready);
endinterface

interface mtw_rsp_if import mtw_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic                  pin_level;
   logic                  reload_valid;
   logic [INTERVAL_W-1:0] next_interval_us;
   logic [TOOTH_W-1:0]    tooth_position;
   modport source (output valid, output pin_level, output reload_valid,
                   output next_interval_us, output tooth_position, input ready);
   modport sink   (input valid, input pin_level, input reload_valid,
                   input next_interval_us, input tooth_position, output ready);
endinterface

interface mtw_csr_if import mtw_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/mtw_serial_div.sv
// Bit-serial restoring divider of the constant minute length by a tooth-rate divisor.
module mtw_serial_div import mtw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [INTERVAL_W-1:0] quotient
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [INTERVAL_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = LAST_STEP;
         dvd_in  = MICROS_PER_MINUTE;
         dvs_in  = divisor;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quot_in = {quot_ff[INTERVAL_W-2:0], fits};
         dvd_in  = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: design/missing_tooth_wheel_pulse_generator_core.sv
// Crank trigger wheel generator: one result word per timer alarm word with alarm_tick high.
//
// The req_bus channel carries one word per alarm expiry; a word with alarm_tick
// low is taken and gives no result. Each alarm word with alarm_tick high gives
// one rsp_bus word with the pin level, the reload flag, the next alarm interval
// in microseconds and the tooth position after the tick.
// The csr_bus channel writes output_enable (index 0), engine_rpm (index 1, zero
// is stored as one) and wheel_select (index 2, values past the table are
// ignored); it is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this. While enabled, the tooth
// period 60000000 / (rpm * teeth) comes from a bit-serial divider that retires
// one quotient bit per cycle. An enabled alarm word passes the divide and done
// states before its result enters the output register, and the next word is
// taken only back in idle. A disabled alarm word skips the divide state.
// A finished result waits in the output register while the receiver stalls;
// only a second result waits for that register to free up.
// Reset clears the tooth counter and the level, loads rpm 1000, wheel 36-1,
// output disabled, and empties the output register.
module missing_tooth_wheel_pulse_generator_core import mtw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   mtw_req_if.sink   req_bus,
   mtw_rsp_if.source rsp_bus,
   mtw_csr_if.sink   csr_bus
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_DONE   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic                  en_ff, en_in;
   logic [RPM_W-1:0]      rpm_ff, rpm_in;
   logic [WSEL_W-1:0]     wsel_ff, wsel_in;
   logic [TOOTH_W-1:0]    cnt_ff, cnt_in;
   logic                  lvl_ff, lvl_in;
   logic                  start_ff, start_in;
   logic [DIVISOR_W-1:0]  prod_ff, prod_in;
   logic                  half_ff, half_in;
   logic                  pin_ff, pin_in;
   logic                  reload_ff, reload_in;
   logic [TOOTH_W-1:0]    pos_ff, pos_in;
   logic [INTERVAL_W-1:0] ival_ff, ival_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_pin_ff, out_pin_in;
   logic                  out_reload_ff, out_reload_in;
   logic [INTERVAL_W-1:0] out_ival_ff, out_ival_in;
   logic [TOOTH_W-1:0]    out_pos_ff, out_pos_in;

   wheel_type             wheel;
   logic [TOOTH_W-1:0]    present_cnt;
   logic                  is_present;
   logic                  lvl_next;
   logic [TOOTH_W:0]      cnt_inc;
   logic                  req_take;
   logic                  out_free;
   logic                  div_done;
   logic [INTERVAL_W-1:0] div_quot;

   mtw_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .divisor  (prod_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign out_free      = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      wheel       = wheel_lookup(wsel_ff);
      present_cnt = wheel.teeth - TOOTH_W'(wheel.missing);
      is_present  = cnt_ff < present_cnt;
      lvl_next    = is_present ? !lvl_ff : 1'b0;
      cnt_inc     = {1'b0, cnt_ff} + 1'b1;
   end

   always_comb begin
      en_in   = en_ff;
      rpm_in  = rpm_ff;
      wsel_in = wsel_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_ENABLE: en_in = csr_bus.data[0];
            CSR_RPM: begin
               rpm_in = (csr_bus.data[RPM_W-1:0] == '0) ? RPM_W'(1)
                                                        : csr_bus.data[RPM_W-1:0];
            end
            CSR_WHEEL: begin
               if (int'(csr_bus.data[WSEL_W-1:0]) < WHEEL_TABLE_SIZE) begin
                  wsel_in = csr_bus.data[WSEL_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      lvl_in        = lvl_ff;
      start_in      = 1'b0;
      prod_in       = prod_ff;
      half_in       = half_ff;
      pin_in        = pin_ff;
      reload_in     = reload_ff;
      pos_in        = pos_ff;
      ival_in       = ival_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_pin_in    = out_pin_ff;
      out_reload_in = out_reload_ff;
      out_ival_in   = out_ival_ff;
      out_pos_in    = out_pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_bus.alarm_tick) begin
               if (en_ff) begin
                  lvl_in = lvl_next;
                  if (!lvl_next) begin
                     cnt_in = (cnt_inc >= {1'b0, wheel.teeth}) ? '0
                                                               : cnt_inc[TOOTH_W-1:0];
                     pos_in = cnt_in;
                  end else begin
                     pos_in = cnt_ff;
                  end
                  pin_in    = lvl_next;
                  reload_in = 1'b1;
                  half_in   = is_present;
                  prod_in   = DIVISOR_W'(rpm_ff) * DIVISOR_W'(wheel.teeth);
                  start_in  = 1'b1;
                  state_in  = ST_DIVIDE;
               end else begin
                  pin_in    = 1'b0;
                  reload_in = 1'b0;
                  ival_in   = '0;
                  pos_in    = cnt_ff;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               ival_in  = half_ff ? (div_quot >> 1) : div_quot;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_pin_in    = pin_ff;
               out_reload_in = reload_ff;
               out_ival_in   = ival_ff;
               out_pos_in    = pos_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         en_ff        <= 1'b0;
         rpm_ff       <= RPM_RESET;
         wsel_ff      <= '0;
         cnt_ff       <= '0;
         lvl_ff       <= 1'b0;
         start_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         en_ff        <= en_in;
         rpm_ff       <= rpm_in;
         wsel_ff      <= wsel_in;
         cnt_ff       <= cnt_in;
         lvl_ff       <= lvl_in;
         start_ff     <= start_in;
         out_valid_ff <= out_valid_in;
      end
      prod_ff       <= prod_in;
      half_ff       <= half_in;
      pin_ff        <= pin_in;
      reload_ff     <= reload_in;
      pos_ff        <= pos_in;
      ival_ff       <= ival_in;
      out_pin_ff    <= out_pin_in;
      out_reload_ff <= out_reload_in;
      out_ival_ff   <= out_ival_in;
      out_pos_ff    <= out_pos_in;
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.pin_level        = out_pin_ff;
   assign rsp_bus.reload_valid     = out_reload_ff;
   assign rsp_bus.next_interval_us = out_ival_ff;
   assign rsp_bus.tooth_position   = out_pos_ff;

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> prod_ff != '0)
      else $error("divider started with a zero divisor");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide state");

   a_disabled_word: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_reload_ff |-> !out_pin_ff && out_ival_ff == '0)
      else $error("disabled result word carries a level or an interval");

   a_wheel_range: assert property (@(posedge clock) disable iff (reset)
      int'(wsel_ff) < WHEEL_TABLE_SIZE)
      else $error("wheel select outside the wheel table");

endmodule
